/* src/lld_pkg.sv */
// Shared types and constants for the least-loaded dispatcher.
// Used by lld_ctrl, lld_dp and the top level least_loaded_dispatcher.
package lld_pkg;

    // Sizing of the per-worker counter array.
    localparam int WORKERS    = 16;
    localparam int COUNT_BITS = 16;

    // Fixed field widths of the external interface.
    localparam int OP_W       = 2;
    localparam int WORKER_W   = 4;
    localparam int LOAD_OUT_W = 16;
    localparam int CFG_W      = 5;

    // Derived widths: counter index, active-worker count, common compare width.
    localparam int IDX_W = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int NUM_W = $clog2(WORKERS + 1);
    localparam int CMP_W = (NUM_W > CFG_W) ? NUM_W : CFG_W;

    // Saturation value of a counter.
    localparam logic [COUNT_BITS-1:0] LOAD_MAX = '1;

    // Operation codes of an input transaction.
    typedef enum logic [OP_W-1:0] {
        OP_DISPATCH = 2'd0,
        OP_COMPLETE = 2'd1,
        OP_UNDO     = 2'd2,
        OP_RESERVED = 2'd3
    } op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;   // capture a new input transaction
        logic scan;    // compare one counter against the running minimum
        logic apply;   // update the counter and load the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic new_dispatch;   // the offered input transaction is a dispatch
        logic scan_last;      // the scan stands on the last active worker
    } status_t;

endpackage

/* src/least_loaded_dispatcher.sv */
// Least-loaded dispatcher that picks the worker with the fewest outstanding tasks.
// Top level; instantiates lld_ctrl and lld_dp and depends on lld_pkg.
//
// The block keeps one outstanding-task counter per worker. A dispatch walks the
// active workers one counter per cycle through the single read port of the
// counter array, scanning the effective number of active workers (a worker_count
// of zero counts as one and values above 16 count as 16) before its result is
// applied; a completion, an undo or an unknown operation goes from the idle state
// straight to the apply state. The controller then returns to its idle state. A new
// input transaction is taken as soon as the previous result has entered the output
// register, even while that result still waits to be taken; the next result then
// waits for the output register and the input stalls meanwhile.
// Counters reset to zero and worker_count resets to 1; worker_count should be
// written only while no transaction is in flight, and cfg_ready is always high.
module least_loaded_dispatcher (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [lld_pkg::OP_W-1:0]        operation,
    input  logic [lld_pkg::WORKER_W-1:0]    worker,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [lld_pkg::WORKER_W-1:0]    chosen_worker,
    output logic [lld_pkg::LOAD_OUT_W-1:0]  new_load,
    output logic                            error,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lld_pkg::CFG_W-1:0]       worker_count
);
    import lld_pkg::*;

    cmd_t    cmd;
    status_t status;

    // The configuration register can always take a write.
    assign cfg_ready = 1'b1;

    lld_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    lld_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .operation     (operation),
        .worker        (worker),
        .cfg_write     (cfg_valid && cfg_ready),
        .worker_count  (worker_count),
        .chosen_worker (chosen_worker),
        .new_load      (new_load),
        .error         (error)
    );

endmodule

/* src/lld_ctrl.sv */
// Controller state machine of the least-loaded dispatcher.
// Depends on lld_pkg for the command and status structs.
module lld_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  lld_pkg::status_t status,
    output lld_pkg::cmd_t    cmd
);
    import lld_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_APPLY = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Next-state logic and command decode.
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = in_valid;
                if (in_valid)
                begin
                    state_next = status.new_dispatch ? S_SCAN : S_APPLY;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                // The result may only enter the output register once it is free.
                cmd.apply = !out_valid_reg || out_ready;
                if (cmd.apply)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register valid flag.
    always_comb
    begin
        if (cmd.apply)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A finished result always shows up as a pending output transaction.
    a_apply_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply |=> out_valid_reg)
        else $error("result applied but output not valid");

    // A dispatch always goes through the scan before its result.
    a_dispatch_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start && status.new_dispatch) |=> (state_reg == S_SCAN))
        else $error("dispatch skipped the scan");

    // A blocked result waits in place until the output register frees up.
    a_apply_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY && out_valid_reg && !out_ready) |=>
        (state_reg == S_APPLY && out_valid_reg))
        else $error("pending result lost while output stalled");

endmodule

/* src/lld_dp.sv */
// Datapath of the least-loaded dispatcher: counters, scan, update and output register.
// Depends on lld_pkg for widths, operation codes and the command and status structs.
module lld_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lld_pkg::cmd_t                   cmd,
    output lld_pkg::status_t                status,
    input  logic [lld_pkg::OP_W-1:0]        operation,
    input  logic [lld_pkg::WORKER_W-1:0]    worker,
    input  logic                            cfg_write,
    input  logic [lld_pkg::CFG_W-1:0]       worker_count,
    output logic [lld_pkg::WORKER_W-1:0]    chosen_worker,
    output logic [lld_pkg::LOAD_OUT_W-1:0]  new_load,
    output logic                            error
);
    import lld_pkg::*;

    logic [COUNT_BITS-1:0] loads_reg [WORKERS];
    logic [CFG_W-1:0]      worker_count_reg;
    logic [CFG_W-1:0]      worker_count_next;
    op_t                   op_reg;
    op_t                   op_next;
    logic [WORKER_W-1:0]   worker_reg;
    logic [WORKER_W-1:0]   worker_next;
    logic [IDX_W-1:0]      scan_idx_reg;
    logic [IDX_W-1:0]      scan_idx_next;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [IDX_W-1:0]      best_idx_next;
    logic [COUNT_BITS-1:0] best_load_reg;
    logic [COUNT_BITS-1:0] best_load_next;
    logic [WORKER_W-1:0]   out_worker_reg;
    logic [WORKER_W-1:0]   out_worker_next;
    logic [LOAD_OUT_W-1:0] out_load_reg;
    logic [LOAD_OUT_W-1:0] out_load_next;
    logic                  out_error_reg;
    logic                  out_error_next;

    logic [CMP_W-1:0]      count_wide;
    logic [NUM_W-1:0]      active_n;
    logic                  in_range;
    logic [IDX_W-1:0]      rd_addr;
    logic [COUNT_BITS-1:0] rd_load;
    logic                  wr_en;
    logic [COUNT_BITS-1:0] wr_data;
    logic [WORKER_W-1:0]   res_worker;
    logic [COUNT_BITS-1:0] res_load;
    logic                  res_error;

    // Effective number of active workers: zero counts as one, excess is clipped.
    always_comb
    begin
        count_wide = CMP_W'(worker_count_reg);
        priority if (count_wide == '0)
        begin
            active_n = NUM_W'(1);
        end
        else if (count_wide > CMP_W'(WORKERS))
        begin
            active_n = NUM_W'(WORKERS);
        end
        else
        begin
            active_n = NUM_W'(count_wide);
        end
    end

    assign in_range = CMP_W'(worker_reg) < CMP_W'(active_n);

    // Single read port on the counter array.
    always_comb
    begin
        if (cmd.scan)
        begin
            rd_addr = scan_idx_reg;
        end
        else if (op_reg == OP_DISPATCH)
        begin
            rd_addr = best_idx_reg;
        end
        else
        begin
            rd_addr = IDX_W'(worker_reg);
        end
    end

    assign rd_load = loads_reg[rd_addr];

    // Status back to the controller.
    always_comb
    begin
        status.new_dispatch = (op_t'(operation) == OP_DISPATCH);
        status.scan_last    = (NUM_W'(scan_idx_reg) + NUM_W'(1)) == active_n;
    end

    // Capture of the input transaction and the running minimum of the scan.
    always_comb
    begin
        op_next        = op_reg;
        worker_next    = worker_reg;
        scan_idx_next  = scan_idx_reg;
        best_idx_next  = best_idx_reg;
        best_load_next = best_load_reg;
        if (cmd.start)
        begin
            op_next       = op_t'(operation);
            worker_next   = worker;
            scan_idx_next = '0;
        end
        if (cmd.scan)
        begin
            // Strictly smaller only, so a tie keeps the lower index.
            if (scan_idx_reg == '0 || rd_load < best_load_reg)
            begin
                best_idx_next  = scan_idx_reg;
                best_load_next = rd_load;
            end
            scan_idx_next = scan_idx_reg + IDX_W'(1);
        end
    end

    // Result of the captured operation and the counter update it causes.
    always_comb
    begin
        res_worker = worker_reg;
        res_load   = '0;
        res_error  = 1'b1;
        wr_data    = rd_load;
        wr_en      = 1'b0;
        unique case (op_reg)
            OP_DISPATCH:
            begin
                res_worker = WORKER_W'(best_idx_reg);
                wr_data    = (rd_load == LOAD_MAX) ? rd_load : rd_load + COUNT_BITS'(1);
                res_load   = wr_data;
                res_error  = 1'b0;
                wr_en      = cmd.apply;
            end
            OP_COMPLETE, OP_UNDO:
            begin
                if (in_range && rd_load != '0)
                begin
                    wr_data   = rd_load - COUNT_BITS'(1);
                    res_load  = wr_data;
                    res_error = 1'b0;
                    wr_en     = cmd.apply;
                end
            end
            OP_RESERVED:
            begin
                // Unknown operation reports the current count of an in-range worker and flags an error.
                res_load = in_range ? rd_load : '0;
            end
        endcase
    end

    // Output register and configuration register.
    always_comb
    begin
        out_worker_next   = out_worker_reg;
        out_load_next     = out_load_reg;
        out_error_next    = out_error_reg;
        worker_count_next = worker_count_reg;
        if (cmd.apply)
        begin
            out_worker_next = res_worker;
            out_load_next   = LOAD_OUT_W'(res_load);
            out_error_next  = res_error;
        end
        if (cfg_write)
        begin
            worker_count_next = worker_count;
        end
    end

    // Counters clear and the configuration resets to one worker on reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WORKERS; i++)
            begin
                loads_reg[i] <= '0;
            end
            worker_count_reg <= CFG_W'(1);
        end
        else
        begin
            if (wr_en)
            begin
                loads_reg[rd_addr] <= wr_data;
            end
            worker_count_reg <= worker_count_next;
        end
    end

    // Working and output payload registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg         <= OP_DISPATCH;
            worker_reg     <= '0;
            scan_idx_reg   <= '0;
            best_idx_reg   <= '0;
            best_load_reg  <= '0;
            out_worker_reg <= '0;
            out_load_reg   <= '0;
            out_error_reg  <= 1'b0;
        end
        else
        begin
            op_reg         <= op_next;
            worker_reg     <= worker_next;
            scan_idx_reg   <= scan_idx_next;
            best_idx_reg   <= best_idx_next;
            best_load_reg  <= best_load_next;
            out_worker_reg <= out_worker_next;
            out_load_reg   <= out_load_next;
            out_error_reg  <= out_error_next;
        end
    end

    assign chosen_worker = out_worker_reg;
    assign new_load      = out_load_reg;
    assign error         = out_error_reg;

    // A dispatch never raises the error flag.
    a_dispatch_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.apply && op_reg == OP_DISPATCH) |=> !out_error_reg)
        else $error("dispatch reported an error");

    // A dispatch only ever selects an active worker.
    a_dispatch_active: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.apply && op_reg == OP_DISPATCH) |-> (NUM_W'(best_idx_reg) < active_n))
        else $error("dispatch selected an inactive worker");

    // An unknown operation never touches a counter and always flags an error.
    a_reserved_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.apply && op_reg == OP_RESERVED) |-> (!wr_en && res_error))
        else $error("unknown operation changed a counter");

endmodule

/* tb/least_loaded_dispatcher_tb.sv */
// Self-checking testbench for least_loaded_dispatcher with its own load-tracking model.
// Depends on lld_pkg and the least_loaded_dispatcher RTL. It needs no files or arguments.
module least_loaded_dispatcher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lld_pkg::*;

    // Run-shaping constants.
    localparam int IDLE_PCT        = 29;
    localparam int PRESSURE_CYCLES = 150;
    localparam int RANDOM_PHASES   = 10;
    localparam int PHASE_ITEMS     = 125;
    localparam int MAX_REPORTS     = 40;

    // One result transaction as the block reports it.
    typedef struct packed {
        logic [WORKER_W-1:0]   who;
        logic [LOAD_OUT_W-1:0] load;
        logic                  err;
    } load_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [OP_W-1:0]       operation;
    logic [WORKER_W-1:0]   worker;
    logic                  out_valid;
    logic                  out_ready;
    logic [WORKER_W-1:0]   chosen_worker;
    logic [LOAD_OUT_W-1:0] new_load;
    logic                  error;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_worker_count;

    // Model state: counters, active-worker setting and pending results.
    logic [COUNT_BITS-1:0] worker_loads [WORKERS];
    logic [CFG_W-1:0]      worker_count_cfg;
    load_result_t          pending_results [$];

    // Run control shared by the stimulus, the receiver and the checker.
    bit no_idle;
    int holds_requested;
    int holds_served;
    int mismatches;
    int results_checked;
    int dispatch_count;
    int decrement_count;
    int error_count;
    int saturated_count;
    int settings_used;

    least_loaded_dispatcher u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .worker        (worker),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .chosen_worker (chosen_worker),
        .new_load      (new_load),
        .error         (error),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .worker_count  (cfg_worker_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Number of workers that take part, after clamping the register value.
    function automatic int effective_workers();
        if (worker_count_cfg == '0)
            return 1;
        if (worker_count_cfg > WORKERS)
            return WORKERS;
        return int'(worker_count_cfg);
    endfunction

    // Updates the model counters for one accepted transaction and returns its result.
    function automatic load_result_t apply_request(op_t op, logic [WORKER_W-1:0] w);
        load_result_t r;
        int n;
        int best;
        n = effective_workers();
        r.who = w;
        r.load = '0;
        r.err = 1'b1;
        case (op)
            OP_DISPATCH:
            begin
                // Smallest count wins; strict compare keeps the lowest index on a tie.
                best = 0;
                for (int i = 1; i < n; i++)
                begin
                    if (worker_loads[i] < worker_loads[best])
                        best = i;
                end
                if (worker_loads[best] != LOAD_MAX)
                    worker_loads[best] = worker_loads[best] + 1'b1;
                else
                    saturated_count++;
                r.who = WORKER_W'(best);
                r.load = worker_loads[best];
                r.err = 1'b0;
                dispatch_count++;
            end
            OP_COMPLETE, OP_UNDO:
            begin
                decrement_count++;
                if (int'(w) < n && worker_loads[w] != '0)
                begin
                    worker_loads[w] = worker_loads[w] - 1'b1;
                    r.load = worker_loads[w];
                    r.err = 1'b0;
                end
            end
            default:
            begin
                // Unknown operation reports the current count of an in-range worker but changes nothing.
                if (int'(w) < n)
                    r.load = worker_loads[w];
            end
        endcase
        if (r.err)
            error_count++;
        return r;
    endfunction

    // Offers one input transaction, with random idle cycles ahead of it.
    task automatic send_request(op_t op, logic [WORKER_W-1:0] w);
        load_result_t expected;
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        worker <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected = apply_request(op, w);
        pending_results = {pending_results, expected};
        @(negedge clk);
    endtask

    // Stops offering input and waits until every pending result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (WORKERS + 4) @(negedge clk);
    endtask

    // Writes the worker_count register; only called while the block is idle.
    task automatic write_worker_count(logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_worker_count <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        worker_count_cfg = value;
        settings_used++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Reset defaults: one worker, every operation, decrement at zero and out of range.
    task automatic test_reset_state();
        send_request(OP_DISPATCH, 4'd15);
        send_request(OP_COMPLETE, 4'd0);
        send_request(OP_UNDO, 4'd0);
        send_request(OP_COMPLETE, 4'd1);
        send_request(OP_RESERVED, 4'd0);
        send_request(OP_DISPATCH, 4'd0);
        send_request(OP_RESERVED, 4'd0);
        send_request(OP_RESERVED, 4'd15);
        drain();
    endtask

    // Full pool: tie-break order, a gap left by an undo, and decrements on idle workers.
    task automatic test_full_pool();
        write_worker_count(5'd16);
        send_request(OP_DISPATCH, 4'd0);
        send_request(OP_DISPATCH, 4'd0);
        send_request(OP_DISPATCH, 4'd0);
        send_request(OP_UNDO, 4'd2);
        send_request(OP_DISPATCH, 4'd9);
        send_request(OP_COMPLETE, 4'd15);
        send_request(OP_RESERVED, 4'd1);
        send_request(OP_COMPLETE, 4'd1);
        drain();
    endtask

    // Register values of zero and above the worker total are clamped.
    task automatic test_count_limits();
        write_worker_count(5'd0);
        send_request(OP_COMPLETE, 4'd1);
        send_request(OP_DISPATCH, 4'd7);
        drain();
        write_worker_count(5'd31);
        send_request(OP_UNDO, 4'd15);
        send_request(OP_DISPATCH, 4'd0);
        drain();
        write_worker_count(5'd17);
        send_request(OP_RESERVED, 4'd15);
        send_request(OP_DISPATCH, 4'd3);
        drain();
    endtask

    // The receiver holds off for a long stretch while input keeps coming, so the block stalls.
    task automatic test_output_backpressure();
        write_worker_count(5'd4);
        no_idle = 1'b1;
        holds_requested++;
        for (int i = 0; i < 12; i++)
            send_request(i % 3 == 0 ? OP_COMPLETE : OP_DISPATCH, WORKER_W'(i % 4));
        no_idle = 1'b0;
        drain();
    endtask

    // Random traffic in phases, each under its own worker_count setting.
    task automatic test_random_traffic();
        logic [CFG_W-1:0]    phase_setting [RANDOM_PHASES];
        op_t                 op;
        logic [WORKER_W-1:0] w;
        int                  roll;
        phase_setting = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd5, 5'd2, 5'd8, 5'd3, 5'd12};
        phase_setting[8] = CFG_W'($urandom_range(0, 31));
        phase_setting[9] = CFG_W'($urandom_range(2, 9));
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_worker_count(phase_setting[p]);
            // One phase runs with no idle cycles on either side.
            no_idle = (p == 3);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 50)
                    op = OP_DISPATCH;
                else if (roll < 72)
                    op = OP_COMPLETE;
                else if (roll < 94)
                    op = OP_UNDO;
                else
                    op = OP_RESERVED;
                if ($urandom_range(0, 9) < 8)
                    w = WORKER_W'($urandom_range(0, effective_workers() - 1));
                else
                    w = WORKER_W'($urandom_range(0, WORKERS - 1));
                send_request(op, w);
            end
            no_idle = 1'b0;
            drain();
        end
    endtask

    // Receiver: random stalls, plus long hold-offs on request.
    initial
    begin : receiver
        int hold_cycles;
        hold_cycles = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles == 0 && holds_served < holds_requested)
            begin
                holds_served++;
                hold_cycles = PRESSURE_CYCLES;
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic report_mismatch(string field, int unsigned want, int unsigned got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    // Checker: each result transaction against the oldest pending expectation.
    always @(posedge clk)
    begin : check_results
        load_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_checked++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, worker %0d load %0d error %0b",
                         $time, chosen_worker, new_load, error);
            end
            else
            begin
                want = pending_results.pop_front();
                if (chosen_worker !== want.who)
                    report_mismatch("chosen_worker", want.who, chosen_worker);
                if (new_load !== want.load)
                    report_mismatch("new_load", want.load, new_load);
                if (error !== want.err)
                    report_mismatch("error", want.err, error);
            end
        end
    end

    // Main sequence.
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_DISPATCH;
        worker = '0;
        cfg_valid = 1'b0;
        cfg_worker_count = '0;
        no_idle = 1'b0;
        holds_requested = 0;
        holds_served = 0;
        mismatches = 0;
        results_checked = 0;
        dispatch_count = 0;
        decrement_count = 0;
        error_count = 0;
        saturated_count = 0;
        settings_used = 0;
        worker_count_cfg = 5'd1;
        for (int i = 0; i < WORKERS; i++)
            worker_loads[i] = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        test_full_pool();
        test_count_limits();
        test_output_backpressure();
        test_random_traffic();
        drain();

        $display("Checked %0d results: %0d dispatches (%0d at the counter limit), %0d decrements,",
                 results_checked, dispatch_count, saturated_count, decrement_count);
        $display("%0d error responses, across %0d worker_count writes.",
                 error_count, settings_used);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
src/lld_pkg.sv
src/lld_ctrl.sv
src/lld_dp.sv
src/least_loaded_dispatcher.sv
tb/least_loaded_dispatcher_tb.sv
